[hw/rtl/hslce_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and character tables for the HTTP status line code extractor.
// Used by the front parser, the record queue and the back end; depends on nothing.

package hslce_pkg;

  // Parser phase within one status line
  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_SEEK,
    PH_CODE,
    PH_SEP,
    PH_DONE
  } phase_e;

  // Reported status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_PREFIX    = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_SHORT     = 3'd4,
    ST_SEP       = 3'd5,
    ST_NONDIGIT  = 3'd6
  } status_e;

  localparam logic [3:0] MinLineLen = 4'd9;
  localparam logic [3:0] VerStart   = 4'd5;
  localparam logic [3:0] PrefixLast = 4'd4;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChNul   = 8'h00;

  // Line state captured at the last byte, handed from front to back
  typedef struct packed {
    logic       short_line;
    logic       err_prefix;
    logic       err_sep;
    logic       err_digit;
    phase_e     phase;
    logic [1:0] digits;
    logic [9:0] code;
    logic       ver_ok;
    logic       sep_space;
  } line_rec_t;

  // One result item, packed as on the output bus
  typedef struct packed {
    logic       space_after_code;
    logic       version_known;
    logic [9:0] status_value;
    status_e    parse_status;
  } result_t;

  // Expected character of "HTTP/" at a given position
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h48;
      3'd1:    ch = 8'h54;
      3'd2:    ch = 8'h54;
      3'd3:    ch = 8'h50;
      3'd4:    ch = 8'h2f;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Expected character of "1.1 " (minor_zero low) or "1.0 " (minor_zero high)
  function automatic logic [7:0] ver_char(input logic [1:0] idx, input logic minor_zero);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h31;
      2'd1:    ch = 8'h2e;
      2'd2:    ch = minor_zero ? 8'h30 : 8'h31;
      default: ch = ChSpace;
    endcase
    return ch;
  endfunction

endpackage

[hw/rtl/hslce_front.sv]
`timescale 1ns / 1ps
// Front end: per-byte parser that tracks prefix, version, code and separator.
// Emits one line record on the last byte; depends on hslce_pkg.

module hslce_front
  import hslce_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      byte_valid_i,
  input  logic [7:0] byte_i,
  input  logic      last_i,
  input  logic      rec_space_i,
  output logic      byte_ready_o,
  output logic      rec_push_o,
  output line_rec_t rec_o
);

  logic [3:0] pos_q, pos_d;
  phase_e     phase_q, phase_d;
  logic [1:0] digits_q, digits_d;
  logic [9:0] code_q, code_d;
  logic       err_prefix_q, err_prefix_d;
  logic       err_sep_q, err_sep_d;
  logic       err_digit_q, err_digit_d;
  logic [1:0] ver_match_q, ver_match_d;
  logic       sep_space_q, sep_space_d;

  logic       accept;
  logic [3:0] ver_rel;
  logic [9:0] code_x10;
  logic [1:0] digits_inc;

  assign byte_ready_o = rec_space_i;
  assign accept       = byte_valid_i && rec_space_i;
  assign ver_rel      = pos_q - VerStart;
  assign code_x10     = {code_q[6:0], 3'b000} + {code_q[8:0], 1'b0};
  assign digits_inc   = digits_q + 2'd1;

  // Work out the state after this byte
  always_comb begin
    pos_d        = pos_q;
    phase_d      = phase_q;
    digits_d     = digits_q;
    code_d       = code_q;
    err_prefix_d = err_prefix_q;
    err_sep_d    = err_sep_q;
    err_digit_d  = err_digit_q;
    ver_match_d  = ver_match_q;
    sep_space_d  = sep_space_q;

    if (pos_q >= VerStart && pos_q < MinLineLen) begin
      if (byte_i != ver_char(ver_rel[1:0], 1'b0)) ver_match_d[0] = 1'b0;
      if (byte_i != ver_char(ver_rel[1:0], 1'b1)) ver_match_d[1] = 1'b0;
    end

    case (phase_q)
      PH_PREFIX: begin
        if (pos_q <= PrefixLast && byte_i != prefix_char(pos_q[2:0])) err_prefix_d = 1'b1;
        if (pos_q >= PrefixLast) phase_d = PH_SEEK;
      end
      PH_SEEK: begin
        if (byte_i == ChSpace) phase_d = PH_CODE;
      end
      PH_CODE: begin
        if (byte_i inside {[8'h30:8'h39]}) begin
          code_d = code_x10 + {6'd0, byte_i[3:0]};
        end else begin
          err_digit_d = 1'b1;
        end
        digits_d = digits_inc;
        if (digits_inc == 2'd3) phase_d = PH_SEP;
      end
      PH_SEP: begin
        if (byte_i == ChSpace) begin
          sep_space_d = 1'b1;
        end else if (byte_i != ChCr && byte_i != ChLf && byte_i != ChNul) begin
          err_sep_d = 1'b1;
        end
        phase_d = PH_DONE;
      end
      default: ;
    endcase

    if (pos_q < MinLineLen) pos_d = pos_q + 4'd1;
  end

  // Snapshot the line for the back end on the last byte
  always_comb begin
    rec_o.short_line = pos_d < MinLineLen;
    rec_o.err_prefix = err_prefix_d;
    rec_o.err_sep    = err_sep_d;
    rec_o.err_digit  = err_digit_d;
    rec_o.phase      = phase_d;
    rec_o.digits     = digits_d;
    rec_o.code       = code_d;
    rec_o.ver_ok     = ver_match_d != 2'b00;
    rec_o.sep_space  = sep_space_d;
  end

  assign rec_push_o = accept && last_i;

  // Advance per byte; restart at the line end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= 4'd0;
      phase_q      <= PH_PREFIX;
      digits_q     <= 2'd0;
      code_q       <= 10'd0;
      err_prefix_q <= 1'b0;
      err_sep_q    <= 1'b0;
      err_digit_q  <= 1'b0;
      ver_match_q  <= 2'b11;
      sep_space_q  <= 1'b0;
    end else if (accept) begin
      if (last_i) begin
        pos_q        <= 4'd0;
        phase_q      <= PH_PREFIX;
        digits_q     <= 2'd0;
        code_q       <= 10'd0;
        err_prefix_q <= 1'b0;
        err_sep_q    <= 1'b0;
        err_digit_q  <= 1'b0;
        ver_match_q  <= 2'b11;
        sep_space_q  <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        phase_q      <= phase_d;
        digits_q     <= digits_d;
        code_q       <= code_d;
        err_prefix_q <= err_prefix_d;
        err_sep_q    <= err_sep_d;
        err_digit_q  <= err_digit_d;
        ver_match_q  <= ver_match_d;
        sep_space_q  <= sep_space_d;
      end
    end
  end

endmodule

[hw/rtl/hslce_queue.sv]
`timescale 1ns / 1ps
// Short queue of line records between the front parser and the back end.
// Register-array FIFO with a fill count; depends on hslce_pkg.

module hslce_queue
  import hslce_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  line_rec_t push_rec_i,
  output logic      space_o,
  input  logic      pop_i,
  output logic      avail_o,
  output line_rec_t pop_rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  line_rec_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign space_o   = count_q != CntFull;
  assign avail_o   = count_q != '0;
  assign pop_rec_o = mem_q[rd_ptr_q];

  // Store pushed records
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_rec_i;
  end

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i)      count_q <= count_q + CntW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CntW'(1);
    end
  end

endmodule

[hw/rtl/hslce_back.sv]
`timescale 1ns / 1ps
// Back end: judges a queued line record and holds the result in an output register.
// Depends on hslce_pkg.

module hslce_back
  import hslce_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rec_avail_i,
  input  line_rec_t rec_i,
  output logic      rec_pop_o,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output result_t   res_o
);

  logic    valid_q;
  result_t res_q, res_d;
  status_e status;

  assign rec_pop_o   = rec_avail_i && (!valid_q || res_ready_i);
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  // Pick the first status that applies, in check order
  always_comb begin
    if (rec_i.short_line) begin
      status = ST_TOO_SHORT;
    end else if (rec_i.err_prefix) begin
      status = ST_PREFIX;
    end else if (rec_i.phase == PH_SEEK || (rec_i.phase == PH_CODE && rec_i.digits == 2'd0)) begin
      status = ST_NO_SPACE;
    end else if (rec_i.phase == PH_CODE) begin
      status = ST_SHORT;
    end else if (rec_i.err_sep) begin
      status = ST_SEP;
    end else if (rec_i.err_digit) begin
      status = ST_NONDIGIT;
    end else begin
      status = ST_OK;
    end
  end

  // Zero the info fields unless the line is good
  always_comb begin
    res_d.parse_status     = status;
    res_d.status_value     = (status == ST_OK) ? rec_i.code : 10'd0;
    res_d.version_known    = (status == ST_OK) && rec_i.ver_ok;
    res_d.space_after_code = (status == ST_OK) && rec_i.sep_space;
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) res_q <= res_d;
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rec_pop_o) begin
      valid_q <= 1'b1;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

[hw/rtl/http_status_line_code_extractor_top.sv]
`timescale 1ns / 1ps
// Top level of the HTTP status line code extractor: front parser, record queue, back end.
// Depends on hslce_pkg, hslce_front, hslce_queue and hslce_back.
//
//   Channel   Direction  Payload (low bit up)                         Transfers
//   s_axis    in         tdata: line_byte[7:0]; tlast: end_of_line     one byte per line position
//   m_axis    out        tdata: parse_status[2:0], status_value[12:3], one per line
//                        version_known[13], space_after_code[14], 0
//
// One byte is taken every cycle while the record queue has space; the per-byte parser register
// set is the only loop. A line's result passes the queue, then the output register.
// Reset clears parser state, queue pointers and the output valid; no clearing pass.
// A stalled sink fills the result queue; input stalls only when QueueDepth records
// sit in the queue behind a held result, so QueueDepth + 1 results wait.

module http_status_line_code_extractor_top
  import hslce_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // line_byte[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // parse_status, status_value, version_known,
                                     // space_after_code, zero fill
);

  logic      rec_push, rec_space, rec_pop, rec_avail;
  line_rec_t rec_in, rec_out;
  result_t   result;

  hslce_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .rec_space_i  (rec_space),
    .byte_ready_o (s_axis_tready),
    .rec_push_o   (rec_push),
    .rec_o        (rec_in)
  );

  hslce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (rec_push),
    .push_rec_i (rec_in),
    .space_o    (rec_space),
    .pop_i      (rec_pop),
    .avail_o    (rec_avail),
    .pop_rec_o  (rec_out)
  );

  hslce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_avail_i (rec_avail),
    .rec_i       (rec_out),
    .rec_pop_o   (rec_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (result)
  );

  // Pad the packed result to whole bytes
  assign m_axis_tdata = {1'b0, result};

endmodule

[dv/http_status_line_code_extractor_checker.sv]
`timescale 1ns / 1ps
// Checker for the HTTP status line code extractor: watches both stream channels,
// predicts each line's result from the accepted bytes and compares results in order.
// Depends on hslce_pkg for the phase and status codes and the result layout.

module http_status_line_code_extractor_checker
  import hslce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // line_byte[7:0]
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // parse_status, status_value, version_known,
                                      // space_after_code, zero fill
  output int          fail_count_o,
  output int          pending_o
);

  // Character k of each text sits at bits 8*(len-1-k) of its packed literal
  localparam logic [39:0] HttpText  = "HTTP/";
  localparam logic [31:0] Ver11Text = "1.1 ";
  localparam logic [31:0] Ver10Text = "1.0 ";

  // Parser state rebuilt from the accepted bytes of the current line
  logic [3:0] line_pos;
  phase_e     line_phase;
  logic [1:0] code_digits;
  logic [9:0] code_value;
  logic       bad_prefix;
  logic       bad_sep;
  logic       bad_digit;
  logic [1:0] ver_candidates;
  logic       sep_is_space;

  result_t line_results_q[$];
  int      mismatches = 0;

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    mismatches++;
    $display("%0t: %s: got %0d, expected %0d", $time, what, got_v, want_v);
  endtask

  task automatic clear_line();
    line_pos       = '0;
    line_phase     = PH_PREFIX;
    code_digits    = '0;
    code_value     = '0;
    bad_prefix     = 1'b0;
    bad_sep        = 1'b0;
    bad_digit      = 1'b0;
    ver_candidates = 2'b11;
    sep_is_space   = 1'b0;
  endtask

  // Advance the line state by one byte; judge the line on its last byte
  task automatic take_line_byte(input logic [7:0] b, input logic last);
    result_t res;
    if (line_pos >= VerStart && line_pos <= 4'd8) begin
      if (b != Ver11Text[8*(8 - line_pos) +: 8]) ver_candidates[0] = 1'b0;
      if (b != Ver10Text[8*(8 - line_pos) +: 8]) ver_candidates[1] = 1'b0;
    end

    case (line_phase)
      PH_PREFIX: begin
        if (line_pos <= PrefixLast && b != HttpText[8*(4 - line_pos) +: 8]) bad_prefix = 1'b1;
        if (line_pos >= PrefixLast) line_phase = PH_SEEK;
      end
      PH_SEEK: begin
        if (b == ChSpace) line_phase = PH_CODE;
      end
      PH_CODE: begin
        if (b >= 8'h30 && b <= 8'h39) code_value = code_value * 10 + (b - 8'h30);
        else bad_digit = 1'b1;
        code_digits = code_digits + 2'd1;
        if (code_digits == 2'd3) line_phase = PH_SEP;
      end
      PH_SEP: begin
        if (b == ChSpace) sep_is_space = 1'b1;
        else if (b != ChCr && b != ChLf && b != ChNul) bad_sep = 1'b1;
        line_phase = PH_DONE;
      end
      default: ;
    endcase

    if (line_pos < MinLineLen) line_pos = line_pos + 4'd1;

    if (last) begin
      res = '0;
      if (line_pos < MinLineLen) res.parse_status = ST_TOO_SHORT;
      else if (bad_prefix) res.parse_status = ST_PREFIX;
      else if (line_phase == PH_SEEK || (line_phase == PH_CODE && code_digits == 2'd0))
        res.parse_status = ST_NO_SPACE;
      else if (line_phase == PH_CODE) res.parse_status = ST_SHORT;
      else if (bad_sep) res.parse_status = ST_SEP;
      else if (bad_digit) res.parse_status = ST_NONDIGIT;
      else begin
        res.parse_status     = ST_OK;
        res.status_value     = code_value;
        res.version_known    = |ver_candidates;
        res.space_after_code = sep_is_space;
      end
      line_results_q.push_back(res);
      clear_line();
    end
  endtask

  // Compare one result transfer with the oldest predicted line result
  task automatic check_line_result(input logic [15:0] word);
    result_t got;
    result_t want;
    got = result_t'(word[14:0]);
    if (line_results_q.size() == 0) begin
      report_mismatch("result with no line pending", int'(word), -1);
    end else begin
      want = line_results_q.pop_front();
      if (got.parse_status != want.parse_status)
        report_mismatch("parse_status", int'(got.parse_status), int'(want.parse_status));
      if (got.status_value != want.status_value)
        report_mismatch("status_value", int'(got.status_value), int'(want.status_value));
      if (got.version_known != want.version_known)
        report_mismatch("version_known", int'(got.version_known), int'(want.version_known));
      if (got.space_after_code != want.space_after_code)
        report_mismatch("space_after_code", int'(got.space_after_code),
                        int'(want.space_after_code));
      if (word[15] != 1'b0) report_mismatch("zero fill", int'(word[15]), 0);
    end
  endtask

  // Sample both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      line_results_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) take_line_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_line_result(m_axis_tdata);
    end
    pending_o    = line_results_q.size();
    fail_count_o = mismatches;
  end

endmodule

[dv/http_status_line_code_extractor_top_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the HTTP status line code extractor: clock, reset, status line
// stimulus, sink flow control, watchdog and verdict. Depends on hslce_pkg, the block
// and http_status_line_code_extractor_checker.

module http_status_line_code_extractor_top_tb;
  import hslce_pkg::*;

  localparam int IdleLimit  = 3000;
  localparam int HoldCycles = 120;
  localparam int PhaseBytes = 165;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int fail_count;
  int pending_lines;
  int send_idle_pct = 32;
  int recv_idle_pct = 62;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;
  int bytes_counted = 0;
  int tail_len      = 0;

  logic [7:0] line_q[$];

  http_status_line_code_extractor_top DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  http_status_line_code_extractor_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .fail_count_o (fail_count),
    .pending_o    (pending_lines)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sink flow control: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      m_axis_tready <= 1'b0;
      hold_ack      <= hold_req;
      hold_left     <= HoldCycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Abort when no transfer happens on either channel for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one byte after a random gap; return at the edge that takes it
  task automatic send_byte(input logic [7:0] b, input logic last);
    logic ready_seen;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
    end while (!ready_seen);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_text_line(input string s);
    line_q.delete();
    push_text(s);
    send_line();
  endtask

  task automatic send_byte_line(input logic [7:0] b);
    line_q.delete();
    line_q.push_back(b);
    send_line();
  endtask

  function automatic logic [7:0] any_but_space();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == ChSpace) b = 8'h31;
    return b;
  endfunction

  // Build one random line: mostly well-formed status lines, some damaged,
  // cut short or pure noise
  task automatic make_status_line();
    int kind;
    int n;
    int code;
    int cut;
    int pick;
    logic has_sep;
    line_q.delete();
    tail_len = 0;
    kind = $urandom_range(99);
    if (kind < 70) begin
      push_text("HTTP/");
      case ($urandom_range(7))
        0, 1, 2: push_text("1.1 ");
        3, 4:    push_text("1.0 ");
        5:       push_text("2 ");
        6:       push_text("1.10 ");
        default: begin
          n = $urandom_range(3);
          repeat (n) line_q.push_back(any_but_space());
          line_q.push_back(ChSpace);
        end
      endcase
      pick = $urandom_range(9);
      code = (pick == 0) ? 0 : (pick == 1) ? 999 : $urandom_range(999);
      line_q.push_back(8'h30 + 8'(code / 100));
      line_q.push_back(8'h30 + 8'((code / 10) % 10));
      line_q.push_back(8'h30 + 8'(code % 10));
      has_sep = 1'b1;
      case ($urandom_range(9))
        3:       line_q.push_back(ChCr);
        4:       line_q.push_back(ChLf);
        5:       line_q.push_back(ChNul);
        6:       line_q.push_back(8'($urandom_range(255)));
        7:       has_sep = 1'b0;
        default: line_q.push_back(ChSpace);
      endcase
      if (has_sep) begin
        tail_len = $urandom_range(3);
        repeat (tail_len) line_q.push_back(8'($urandom_range(255)));
      end
      // Damage one byte
      if ($urandom_range(99) < 20)
        line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
      // Cut the line short
      if ($urandom_range(99) < 15) begin
        cut = $urandom_range(1, line_q.size());
        while (line_q.size() > cut) line_q.delete(line_q.size() - 1);
        tail_len = 0;
      end
    end else if (kind < 85) begin
      n = $urandom_range(1, 14);
      repeat (n) line_q.push_back(8'($urandom_range(255)));
    end else begin
      push_text("HTTP/");
      n = $urandom_range(1, 10);
      repeat (n) begin
        case ($urandom_range(2))
          0:       line_q.push_back(ChSpace);
          1:       line_q.push_back(8'h30 + 8'($urandom_range(9)));
          default: line_q.push_back(8'($urandom_range(255)));
        endcase
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: top code with ignored trailing bytes, space as last byte,
    // byte extremes as one-byte lines
    send_text_line("HTTP/1.1 999 x");
    send_text_line("HTTP/2.0 ");
    send_byte_line(8'h00);
    send_byte_line(8'hff);

    // Hold the sink off while short lines keep coming, so the result queue fills
    send_idle_pct = 0;
    hold_req <= hold_req + 1;
    repeat (16) begin
      line_q.delete();
      repeat ($urandom_range(1, 2)) line_q.push_back(8'($urandom_range(255)));
      send_line();
    end

    // Random lines under three idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 62 : 0;
      recv_idle_pct <= (ph == 0) ? 62 : (ph == 1) ? 32 : 0;
      while (bytes_counted < (ph + 1) * PhaseBytes) begin
        make_status_line();
        bytes_counted += line_q.size();
        send_line();
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then allow for the output pipeline
    while (pending_lines != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
